// ===== rtl/axis_min_max_reduction_assert.svh =====
// Assertion macros for the min/max reduction block.
`ifndef AXIS_MIN_MAX_REDUCTION_ASSERT_SVH
`define AXIS_MIN_MAX_REDUCTION_ASSERT_SVH

// Same-cycle implication under reset.
`define AMR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("amr assertion failed");

// Next-cycle implication under reset.
`define AMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("amr assertion failed");

`endif

// ===== rtl/amr_pkg.sv =====
// Shared types, codes and the double compare for the min/max reduction block.
`timescale 1ns / 1ps
`default_nettype none
package amr_pkg;

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_FOLD   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_OVERSIZE = 2'd2;

    localparam logic [2:0] REG_RANK     = 3'd0;
    localparam logic [2:0] REG_EXT0     = 3'd1;
    localparam logic [2:0] REG_EXT1     = 3'd2;
    localparam logic [2:0] REG_EXT2     = 3'd3;
    localparam logic [2:0] REG_EXT3     = 3'd4;
    localparam logic [2:0] REG_MASK     = 3'd5;
    localparam logic [2:0] REG_FIND_MIN = 3'd6;

    localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_START,
        ST_STRIDE,
        ST_CLEAR,
        ST_IDLE,
        ST_FOLD_RD,
        ST_FOLD_WR,
        ST_READ_RD,
        ST_READ_OUT
    } state_t;

    typedef struct packed {
        logic latch;
        logic step;
        logic advance;
    } walk_cmd_t;

    typedef struct packed {
        logic stride_done;
        logic oversize;
        logic geo_min;
    } walk_stat_t;

    function automatic logic is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    // a < b for two non-NaN doubles; the two zeros compare equal
    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic both_zero;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (both_zero) begin
            return 1'b0;
        end else if (a[63] != b[63]) begin
            return a[63];
        end else if (!a[63]) begin
            return a[62:0] < b[62:0];
        end else begin
            return a[62:0] > b[62:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/amr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module amr_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/amr_walk.sv =====
// Geometry latch, stride builder and row-major position walker.
`timescale 1ns / 1ps
`default_nettype none
module amr_walk #(
    parameter int MAX_RANK  = 4,
    parameter int OUT_DEPTH = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire amr_pkg::walk_cmd_t             cmd,
    input  wire logic [2:0]                     cfg_rank,
    input  wire logic [3:0][15:0]               cfg_ext,
    input  wire logic [3:0]                     cfg_mask,
    input  wire logic                           cfg_min,
    output amr_pkg::walk_stat_t                 stat,
    output logic      [$clog2(OUT_DEPTH):0]     out_size,
    output logic      [$clog2(OUT_DEPTH)-1:0]   position
);

    localparam int AW  = $clog2(OUT_DEPTH);
    localparam int SW  = AW + 1;
    localparam int RKW = $clog2(MAX_RANK + 1);
    localparam int DIW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    logic [RKW-1:0]           rank_reg, rank_next;
    logic [MAX_RANK-1:0]      fold_reg, fold_next;
    logic [15:0]              ext_reg    [MAX_RANK];
    logic [15:0]              ext_next   [MAX_RANK];
    logic [15:0]              cnt_reg    [MAX_RANK];
    logic [15:0]              cnt_next   [MAX_RANK];
    logic [SW-1:0]            stride_reg [MAX_RANK];
    logic [SW-1:0]            stride_next[MAX_RANK];
    logic [SW-1:0]            span_reg   [MAX_RANK];
    logic [SW-1:0]            span_next  [MAX_RANK];
    logic [SW-1:0]            running_reg, running_next;
    logic                     oversize_reg, oversize_next;
    logic                     min_reg, min_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [RKW-1:0]           sidx_reg, sidx_next;
    logic [DIW-1:0]           sd;
    logic [SW+15:0]           prod;
    logic [SW-1:0]            delta;
    logic [SW-1:0]            pos_sum;
    logic                     carry;

    assign stat.stride_done = (sidx_reg == '0);
    assign stat.oversize    = oversize_reg;
    assign stat.geo_min     = min_reg;
    assign out_size         = oversize_reg ? '0 : running_reg;
    assign position         = pos_reg;

    always_comb begin
        rank_next     = rank_reg;
        fold_next     = fold_reg;
        ext_next      = ext_reg;
        cnt_next      = cnt_reg;
        stride_next   = stride_reg;
        span_next     = span_reg;
        running_next  = running_reg;
        oversize_next = oversize_reg;
        min_next      = min_reg;
        pos_next      = pos_reg;
        sidx_next     = sidx_reg;
        sd            = DIW'(sidx_reg - RKW'(1));
        prod          = (SW+16)'(running_reg) * (SW+16)'(ext_reg[sd]);
        delta         = '0;
        carry         = 1'b1;
        pos_sum       = '0;

        if (cmd.latch) begin
            // saturate rank, force zero extents to one
            if (32'(cfg_rank) > MAX_RANK) begin
                rank_next = RKW'(MAX_RANK);
            end else begin
                rank_next = RKW'(cfg_rank);
            end
            sidx_next     = rank_next;
            min_next      = cfg_min;
            oversize_next = 1'b0;
            running_next  = SW'(1);
            pos_next      = '0;
            for (int d = 0; d < MAX_RANK; d++) begin
                cnt_next[d]    = '0;
                stride_next[d] = '0;
                span_next[d]   = '0;
                if (d < 4) begin
                    ext_next[d]  = (cfg_ext[2'(d)] == 16'd0) ? 16'd1 : cfg_ext[2'(d)];
                    fold_next[d] = cfg_mask[2'(d)];
                end else begin
                    ext_next[d]  = 16'd1;
                    fold_next[d] = 1'b0;
                end
            end
        end else if (cmd.step && (sidx_reg != '0)) begin
            // one dimension per cycle, innermost first; only surviving ones get a stride
            sidx_next = sidx_reg - RKW'(1);
            if (!fold_reg[sd]) begin
                stride_next[sd] = running_reg;
                if (!oversize_reg) begin
                    if (prod > (SW+16)'(OUT_DEPTH)) begin
                        oversize_next = 1'b1;
                        running_next  = SW'(1);
                    end else begin
                        running_next  = SW'(prod);
                        span_next[sd] = SW'(prod);
                    end
                end
            end
        end else if (cmd.advance) begin
            // odometer step: wrapped dimensions give back their span
            for (int d = MAX_RANK - 1; d >= 0; d--) begin
                if ((d < int'(rank_reg)) && carry) begin
                    if ((17'(cnt_reg[d]) + 17'd1) < 17'(ext_reg[d])) begin
                        cnt_next[d] = cnt_reg[d] + 16'd1;
                        delta       = delta + stride_reg[d];
                        carry       = 1'b0;
                    end else begin
                        cnt_next[d] = '0;
                        delta       = delta + stride_reg[d] - span_reg[d];
                    end
                end
            end
            pos_sum  = SW'(pos_reg) + delta;
            pos_next = pos_sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg     <= '0;
            fold_reg     <= '0;
            running_reg  <= SW'(1);
            oversize_reg <= 1'b0;
            min_reg      <= 1'b0;
            pos_reg      <= '0;
            sidx_reg     <= '0;
            for (int d = 0; d < MAX_RANK; d++) begin
                ext_reg[d]    <= 16'd1;
                cnt_reg[d]    <= '0;
                stride_reg[d] <= '0;
                span_reg[d]   <= '0;
            end
        end else begin
            rank_reg     <= rank_next;
            fold_reg     <= fold_next;
            running_reg  <= running_next;
            oversize_reg <= oversize_next;
            min_reg      <= min_next;
            pos_reg      <= pos_next;
            sidx_reg     <= sidx_next;
            ext_reg      <= ext_next;
            cnt_reg      <= cnt_next;
            stride_reg   <= stride_next;
            span_reg     <= span_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/axis_min_max_reduction.sv =====
// Top level of the streaming min/max reduction over tensor axes.
`timescale 1ns / 1ps
`default_nettype none
// Folds a row-major array of up to MAX_RANK dimensions into a min or max over
// the axes selected by the mask register. Cells live in one RAM word each
// together with a touched bit. A fold item passes accept, RAM read, then
// compare and write back, since the read-modify-write of the cell sets the
// pace. A read item goes from accept straight to the output step when the
// index is out of range or the output is oversize, else through the RAM read
// first, and waits while an earlier result is still held; the result sits in
// an output register so new items are taken while it waits. A begin item
// passes accept, latch, a step for each dimension of the rank capped at
// MAX_RANK and a last check to build the output strides, then a clearing pass
// over every output cell during which no item is accepted; the same pass
// follows reset, one cell long for the reset geometry. Ignored items are
// accepted and dropped. Register writes take effect at the next begin.
module axis_min_max_reduction #(
    parameter int MAX_RANK  = 4,
    parameter int OUT_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // element_bits[63:0], cell_index[73:64], zero pad
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // cell_bits[63:0]
    output logic      [1:0]  m_tuser,   // status[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(OUT_DEPTH);
    localparam int SW = AW + 1;

    amr_pkg::state_t     state_reg, state_next;
    amr_pkg::walk_cmd_t  wcmd;
    amr_pkg::walk_stat_t wstat;

    logic [2:0]       rank_reg;
    logic [3:0][15:0] ext_reg;
    logic [3:0]       mask_reg;
    logic             min_reg;

    logic [SW-1:0]    out_size;
    logic [AW-1:0]    position;
    logic [SW-1:0]    clr_reg, clr_next;
    logic [63:0]      elem_reg, elem_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [1:0]       rstat_reg, rstat_next;
    logic             m_valid_reg, m_valid_next;
    logic [63:0]      m_data_reg, m_data_next;
    logic [1:0]       m_stat_reg, m_stat_next;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [64:0]      ram_wdata, ram_rdata;

    logic             s_acc, out_free, cfg_wr, replace;
    logic [63:0]      cur_bits;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == amr_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;
    assign cur_bits = ram_rdata[63:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= 3'd1;
            ext_reg  <= {4{16'd1}};
            mask_reg <= 4'hF;
            min_reg  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                amr_pkg::REG_RANK:     rank_reg   <= pwdata[2:0];
                amr_pkg::REG_EXT0:     ext_reg[0] <= pwdata[15:0];
                amr_pkg::REG_EXT1:     ext_reg[1] <= pwdata[15:0];
                amr_pkg::REG_EXT2:     ext_reg[2] <= pwdata[15:0];
                amr_pkg::REG_EXT3:     ext_reg[3] <= pwdata[15:0];
                amr_pkg::REG_MASK:     mask_reg   <= pwdata[3:0];
                amr_pkg::REG_FIND_MIN: min_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            amr_pkg::REG_RANK:     prdata = {29'd0, rank_reg};
            amr_pkg::REG_EXT0:     prdata = {16'd0, ext_reg[0]};
            amr_pkg::REG_EXT1:     prdata = {16'd0, ext_reg[1]};
            amr_pkg::REG_EXT2:     prdata = {16'd0, ext_reg[2]};
            amr_pkg::REG_EXT3:     prdata = {16'd0, ext_reg[3]};
            amr_pkg::REG_MASK:     prdata = {28'd0, mask_reg};
            amr_pkg::REG_FIND_MIN: prdata = {31'd0, min_reg};
            default:               prdata = 32'd0;
        endcase
    end

    amr_walk #(
        .MAX_RANK (MAX_RANK),
        .OUT_DEPTH(OUT_DEPTH)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (wcmd),
        .cfg_rank(rank_reg),
        .cfg_ext (ext_reg),
        .cfg_mask(mask_reg),
        .cfg_min (min_reg),
        .stat    (wstat),
        .out_size(out_size),
        .position(position)
    );

    amr_ram #(
        .WIDTH(65),
        .DEPTH(OUT_DEPTH)
    ) u_cells (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // NaN overwrites and sticks; a tie keeps the older value
    always_comb begin
        replace = !ram_rdata[64] || amr_pkg::is_nan(elem_reg) ||
                  (!amr_pkg::is_nan(cur_bits) &&
                   (wstat.geo_min ? amr_pkg::fp_lt(elem_reg, cur_bits)
                                  : amr_pkg::fp_lt(cur_bits, elem_reg)));
    end

    always_comb begin
        state_next   = state_reg;
        wcmd         = '0;
        clr_next     = clr_reg;
        elem_next    = elem_reg;
        addr_next    = addr_reg;
        rstat_next   = rstat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_stat_next  = m_stat_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = {1'b1, replace ? elem_reg : cur_bits};
        ram_re       = 1'b0;
        ram_raddr    = addr_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            amr_pkg::ST_START: begin
                wcmd.latch = 1'b1;
                clr_next   = '0;
                state_next = amr_pkg::ST_STRIDE;
            end
            amr_pkg::ST_STRIDE: begin
                if (wstat.stride_done) begin
                    state_next = amr_pkg::ST_CLEAR;
                end else begin
                    wcmd.step = 1'b1;
                end
            end
            amr_pkg::ST_CLEAR: begin
                if (clr_reg == out_size) begin
                    state_next = amr_pkg::ST_IDLE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = clr_reg[AW-1:0];
                    ram_wdata = '0;
                    clr_next  = clr_reg + SW'(1);
                end
            end
            amr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_tuser)
                        amr_pkg::MODE_BEGIN: state_next = amr_pkg::ST_START;
                        amr_pkg::MODE_FOLD: begin
                            if (!wstat.oversize) begin
                                elem_next  = s_tdata[63:0];
                                state_next = amr_pkg::ST_FOLD_RD;
                            end
                        end
                        amr_pkg::MODE_READ: begin
                            addr_next = AW'(s_tdata[73:64]);
                            if (wstat.oversize) begin
                                rstat_next = amr_pkg::STAT_OVERSIZE;
                                state_next = amr_pkg::ST_READ_OUT;
                            end else if (32'(s_tdata[73:64]) >= 32'(out_size)) begin
                                rstat_next = amr_pkg::STAT_RANGE;
                                state_next = amr_pkg::ST_READ_OUT;
                            end else begin
                                rstat_next = amr_pkg::STAT_OK;
                                state_next = amr_pkg::ST_READ_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            amr_pkg::ST_FOLD_RD: begin
                ram_re       = 1'b1;
                ram_raddr    = position;
                addr_next    = position;
                wcmd.advance = 1'b1;
                state_next   = amr_pkg::ST_FOLD_WR;
            end
            amr_pkg::ST_FOLD_WR: begin
                ram_we     = 1'b1;
                state_next = amr_pkg::ST_IDLE;
            end
            amr_pkg::ST_READ_RD: begin
                ram_re     = 1'b1;
                state_next = amr_pkg::ST_READ_OUT;
            end
            amr_pkg::ST_READ_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_stat_next  = rstat_reg;
                    if (rstat_reg != amr_pkg::STAT_OK) begin
                        m_data_next = '0;
                    end else if (ram_rdata[64]) begin
                        m_data_next = cur_bits;
                    end else begin
                        m_data_next = wstat.geo_min ? amr_pkg::POS_INF_BITS
                                                    : amr_pkg::NEG_INF_BITS;
                    end
                    state_next = amr_pkg::ST_IDLE;
                end
            end
            default: state_next = amr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= amr_pkg::ST_START;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg   <= elem_next;
        addr_reg   <= addr_next;
        rstat_reg  <= rstat_next;
        m_data_reg <= m_data_next;
        m_stat_reg <= m_stat_next;
    end

`include "axis_min_max_reduction_assert.svh"

    `AMR_ASSERT_SAME(a_oversize_empty, aclk, aresetn,
        (state_reg == amr_pkg::ST_IDLE) && wstat.oversize, out_size == '0)
    `AMR_ASSERT_SAME(a_pos_in_range, aclk, aresetn,
        (state_reg == amr_pkg::ST_IDLE) && !wstat.oversize,
        32'(position) < 32'(out_size))
    `AMR_ASSERT_SAME(a_write_source, aclk, aresetn, ram_we,
        (state_reg == amr_pkg::ST_FOLD_WR) || (state_reg == amr_pkg::ST_CLEAR))
    `AMR_ASSERT_NEXT(a_result_issued, aclk, aresetn,
        (state_reg == amr_pkg::ST_READ_OUT) && out_free, m_tvalid)

endmodule
`default_nettype wire
